>>> src/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

   // frame layout
   localparam int unsigned MAX_PAYLOAD = 125;
   localparam logic [7:0] HEADER_BYTES = 8'd3;
   localparam logic [7:0] FRAME_OVERHEAD = 8'd4;
   localparam logic [7:0] POS_TYPE = 8'd1;
   localparam logic [7:0] POS_LENGTH = 8'd2;
   localparam logic [7:0] MAX_LENGTH = 8'(MAX_PAYLOAD);
   localparam logic [7:0] SIZE_AT_RESET = 8'(MAX_PAYLOAD + 5);

   // result kinds
   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   // frame status codes
   typedef enum logic [1:0] {
      STATUS_GOOD    = 2'd0,
      STATUS_LEN_ERR = 2'd1,
      STATUS_CHK_ERR = 2'd2
   } status_type;

   // one result item
   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      logic [6:0] byte_index;
      logic [7:0] frame_type;
      logic [6:0] frame_length;
      status_type status;
   } result_type;

endpackage

>>> src/sfd_if.sv
`timescale 1ns / 1ps

// received byte channel
interface sfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// result channel
interface sfd_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] payload_byte;
   logic [6:0] byte_index;
   logic [7:0] frame_type;
   logic [6:0] frame_length;
   logic [1:0] status;
   modport source (output valid, output kind, output payload_byte, output byte_index,
                   output frame_type, output frame_length, output status, input ready);
   modport sink (input valid, input kind, input payload_byte, input byte_index,
                 input frame_type, input frame_length, input status, output ready);
endinterface

// configuration write channel
interface sfd_csr_if;
   logic valid;
   logic ready;
   logic check_enable;
   modport source (output valid, output check_enable, input ready);
   modport sink (input valid, input check_enable, output ready);
endinterface

>>> src/serial_frame_deframer.sv
`timescale 1ns / 1ps

// serial frame deframer
// req carries one received byte per item; frames are [start][type][length]
// [payload][check]. rsp carries one item per payload byte (kind payload, with
// its index) and one status item on the last byte of each frame (type, length
// and good / length error / check mismatch). Header bytes give no item.
// csr writes check_enable; it is always ready and should only be written while
// the block is idle.
// throughput: one byte per cycle while rsp keeps taking items, set by the single-pass
// byte update between the input register and the result register.
// when rsp stalls, the result register plus a skid slot hold up to two items;
// req.ready drops once the skid slot and input register are full, and rises
// again as soon as rsp takes an item.
// reset (synchronous, active high) empties all registers, restarts the frame
// count and sets check_enable to 1.
module serial_frame_deframer (
   input  logic         clock,
   input  logic         reset,
   sfd_req_if.sink      req,
   sfd_rsp_if.source    rsp,
   sfd_csr_if.sink      csr
);

   logic                check_enable_ff, check_enable_in;
   logic                res_valid;
   logic                res_ready;
   sfd_pkg::result_type res_data;
   sfd_pkg::result_type out_data;

   // configuration register
   assign csr.ready = 1'b1;

   always_comb begin
      check_enable_in = check_enable_ff;
      if (csr.valid && csr.ready) begin
         check_enable_in = csr.check_enable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_enable_ff <= 1'b1;
      end else begin
         check_enable_ff <= check_enable_in;
      end
   end

   // byte parser
   sfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req.valid),
      .in_byte      (req.rx_byte),
      .in_ready     (req.ready),
      .check_enable (check_enable_ff),
      .res_ready    (res_ready),
      .res_valid    (res_valid),
      .res_data     (res_data)
   );

   // result register with skid slot
   sfd_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .in_ready  (res_ready),
      .out_valid (rsp.valid),
      .out_data  (out_data),
      .out_ready (rsp.ready)
   );

   assign rsp.kind         = out_data.kind;
   assign rsp.payload_byte = out_data.payload_byte;
   assign rsp.byte_index   = out_data.byte_index;
   assign rsp.frame_type   = out_data.frame_type;
   assign rsp.frame_length = out_data.frame_length;
   assign rsp.status       = out_data.status;

endmodule

>>> src/sfd_parser.sv
`timescale 1ns / 1ps

module sfd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [7:0]            in_byte,
   output logic                  in_ready,
   input  logic                  check_enable,
   input  logic                  res_ready,
   output logic                  res_valid,
   output sfd_pkg::result_type   res_data
);

   logic       byte_valid_ff, byte_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [7:0] byte_count_ff, byte_count_in;
   logic [7:0] frame_size_ff, frame_size_in;
   logic [7:0] running_xor_ff, running_xor_in;
   logic [7:0] held_type_ff, held_type_in;
   logic [7:0] held_length_ff, held_length_in;
   logic       length_bad_ff, length_bad_in;
   logic       advance;
   logic       in_header;
   logic       frame_end;
   logic [7:0] index_full;

   // input register moves on when the output side can take a result
   assign advance  = byte_valid_ff && res_ready;
   assign in_ready = !byte_valid_ff || res_ready;

   assign in_header  = byte_count_ff < sfd_pkg::HEADER_BYTES;
   assign frame_end  = ({1'b0, byte_count_ff} + 9'd1) >= {1'b0, frame_size_ff};
   assign index_full = byte_count_ff - sfd_pkg::HEADER_BYTES;

   // input register
   always_comb begin
      byte_valid_in = byte_valid_ff;
      byte_in       = byte_ff;
      if (in_valid && in_ready) begin
         byte_valid_in = 1'b1;
         byte_in       = in_byte;
      end else if (advance) begin
         byte_valid_in = 1'b0;
      end
   end

   // frame state update and result
   always_comb begin
      byte_count_in  = byte_count_ff;
      frame_size_in  = frame_size_ff;
      running_xor_in = running_xor_ff;
      held_type_in   = held_type_ff;
      held_length_in = held_length_ff;
      length_bad_in  = length_bad_ff;
      res_valid      = 1'b0;
      res_data       = '0;
      if (advance) begin
         if (in_header) begin
            // start, type and length bytes
            if (byte_count_ff == sfd_pkg::POS_TYPE) begin
               held_type_in   = byte_ff;
               running_xor_in = byte_ff;
            end else if (byte_count_ff == sfd_pkg::POS_LENGTH) begin
               held_length_in = byte_ff;
               running_xor_in = running_xor_ff ^ byte_ff;
               if (byte_ff > sfd_pkg::MAX_LENGTH) begin
                  length_bad_in = 1'b1;
                  frame_size_in = sfd_pkg::FRAME_OVERHEAD;
               end else begin
                  frame_size_in = byte_ff + sfd_pkg::FRAME_OVERHEAD;
               end
            end
            byte_count_in = byte_count_ff + 8'd1;
         end else if (frame_end) begin
            // last byte: status item, then clear the frame
            res_valid           = 1'b1;
            res_data.kind       = sfd_pkg::KIND_STATUS;
            res_data.frame_type = held_type_ff;
            if (length_bad_ff) begin
               res_data.status = sfd_pkg::STATUS_LEN_ERR;
            end else begin
               res_data.frame_length = held_length_ff[6:0];
               if (check_enable && running_xor_ff != byte_ff) begin
                  res_data.status = sfd_pkg::STATUS_CHK_ERR;
               end else begin
                  res_data.status = sfd_pkg::STATUS_GOOD;
               end
            end
            byte_count_in  = '0;
            running_xor_in = '0;
            held_type_in   = '0;
            held_length_in = '0;
            length_bad_in  = 1'b0;
         end else begin
            // payload byte passed on
            res_valid             = 1'b1;
            res_data.kind         = sfd_pkg::KIND_PAYLOAD;
            res_data.payload_byte = byte_ff;
            res_data.byte_index   = index_full[6:0];
            running_xor_in        = running_xor_ff ^ byte_ff;
            byte_count_in         = byte_count_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff  <= 1'b0;
         byte_count_ff  <= '0;
         frame_size_ff  <= sfd_pkg::SIZE_AT_RESET;
         running_xor_ff <= '0;
         held_type_ff   <= '0;
         held_length_ff <= '0;
         length_bad_ff  <= 1'b0;
      end else begin
         byte_valid_ff  <= byte_valid_in;
         byte_count_ff  <= byte_count_in;
         frame_size_ff  <= frame_size_in;
         running_xor_ff <= running_xor_in;
         held_type_ff   <= held_type_in;
         held_length_ff <= held_length_in;
         length_bad_ff  <= length_bad_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // once past the header the count stays inside the frame
   assert property (@(posedge clock) disable iff (reset)
      (byte_count_ff >= sfd_pkg::HEADER_BYTES) |-> (byte_count_ff < frame_size_ff))
      else $error("byte count beyond frame size");

   // an oversize length always shortens the frame to its overhead
   assert property (@(posedge clock) disable iff (reset)
      length_bad_ff |-> (frame_size_ff == sfd_pkg::FRAME_OVERHEAD))
      else $error("length error without short frame");

   // a status item restarts the frame
   assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_data.kind == sfd_pkg::KIND_STATUS) |=> (byte_count_ff == 8'd0))
      else $error("frame not restarted after status");

endmodule

>>> src/sfd_out_skid.sv
`timescale 1ns / 1ps

module sfd_out_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  sfd_pkg::result_type   in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   output sfd_pkg::result_type   out_data,
   input  logic                  out_ready
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   sfd_pkg::result_type main_ff, main_in;
   sfd_pkg::result_type skid_ff, skid_in;
   logic                take;

   // upstream ready only depends on the skid register
   assign in_ready  = !skid_valid_ff;
   assign take      = in_valid && in_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // main register refills from skid first, then from upstream
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = take;
            main_in       = in_data;
         end
      end else if (take) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // the skid slot only fills behind a held result
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid item without main item");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam logic [7:0] START_BYTE = 8'h02;
   localparam int DIRECTED_COUNT = 27;
   // index in the directed bytes at which the check byte test is switched off
   localparam int CHECK_OFF_AT = 22;
   localparam int DRAIN_CYCLES = 8;
   localparam int RSP_HOLD_CYCLES = 90;

   // hand-built frames: good empty frame, bad check on an empty frame, two-byte
   // payload at the byte extremes, length one above the limit, length 255, then
   // a frame with a wrong check byte sent while checking is off
   localparam logic [7:0] DIRECTED_BYTES [DIRECTED_COUNT] = '{
      START_BYTE, 8'h00, 8'h00, 8'h00,
      8'hFF, 8'hFF, 8'h00, 8'h00,
      START_BYTE, 8'hA5, 8'h02, 8'h00, 8'hFF, 8'h58,
      START_BYTE, 8'h3C, 8'h7E, 8'h11,
      START_BYTE, 8'hC3, 8'hFF, 8'h00,
      START_BYTE, 8'h81, 8'h01, 8'h40, 8'h00
   };

   // frame tracker: follows the byte stream and holds the items still due
   class frame_tracker;
      logic       check_enable;
      logic [7:0] byte_count;
      logic [7:0] frame_size;
      logic [7:0] running_xor;
      logic [7:0] held_type;
      logic [7:0] held_length;
      logic       length_bad;
      sfd_pkg::result_type due_items[$];
      int         errors;

      function new();
         check_enable = 1'b1;
         frame_size = sfd_pkg::SIZE_AT_RESET;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         byte_count = '0;
         running_xor = '0;
         held_type = '0;
         held_length = '0;
         length_bad = 1'b0;
      endfunction

      function void set_check_enable(input logic value);
         check_enable = value;
      endfunction

      function int pending();
         return due_items.size();
      endfunction

      // one accepted byte; header bytes give no item
      function void take_byte(input logic [7:0] value);
         sfd_pkg::result_type item;
         item = '0;
         if (byte_count < sfd_pkg::HEADER_BYTES) begin
            if (byte_count == sfd_pkg::POS_TYPE) begin
               held_type = value;
               running_xor = value;
            end else if (byte_count == sfd_pkg::POS_LENGTH) begin
               held_length = value;
               running_xor = running_xor ^ value;
               if (value > sfd_pkg::MAX_LENGTH) begin
                  length_bad = 1'b1;
                  frame_size = sfd_pkg::FRAME_OVERHEAD;
               end else begin
                  frame_size = value + sfd_pkg::FRAME_OVERHEAD;
               end
            end
            byte_count = byte_count + 8'd1;
            return;
         end
         if (int'(byte_count) + 1 >= int'(frame_size)) begin
            // last byte of the frame: status item
            item.kind = sfd_pkg::KIND_STATUS;
            item.frame_type = held_type;
            if (length_bad) begin
               item.status = sfd_pkg::STATUS_LEN_ERR;
               item.frame_length = '0;
            end else if (check_enable && running_xor != value) begin
               item.status = sfd_pkg::STATUS_CHK_ERR;
               item.frame_length = held_length[6:0];
            end else begin
               item.status = sfd_pkg::STATUS_GOOD;
               item.frame_length = held_length[6:0];
            end
            clear_frame();
         end else begin
            // payload byte passed on with its position
            running_xor = running_xor ^ value;
            item.kind = sfd_pkg::KIND_PAYLOAD;
            item.payload_byte = value;
            item.byte_index = 7'(byte_count - sfd_pkg::HEADER_BYTES);
            byte_count = byte_count + 8'd1;
         end
         due_items.push_back(item);
      endfunction

      function void compare_field(input string field, input int unsigned want,
                                  input int unsigned got);
         if (want != got) begin
            $error("%s expected %0d actual %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_item(input sfd_pkg::result_type got);
         sfd_pkg::result_type want;
         if (due_items.size() == 0) begin
            $error("result item with none due: kind %0d", got.kind);
            errors++;
            return;
         end
         want = due_items.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
         compare_field("byte_index", want.byte_index, got.byte_index);
         compare_field("frame_type", want.frame_type, got.frame_type);
         compare_field("frame_length", want.frame_length, got.frame_length);
         compare_field("status", want.status, got.status);
      endfunction
   endclass

   logic clock;
   logic reset;
   sfd_req_if req();
   sfd_rsp_if rsp();
   sfd_csr_if csr();

   frame_tracker frames;
   int  items_sent;
   bit  no_idle;
   int  rsp_hold_left;

   serial_frame_deframer i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("serial_frame_deframer: mismatch");
      $finish;
   end

   // result side: check accepted items, random stalls and the long hold-off
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         frames.check_item('{kind: sfd_pkg::kind_type'(rsp.kind),
                             payload_byte: rsp.payload_byte,
                             byte_index: rsp.byte_index, frame_type: rsp.frame_type,
                             frame_length: rsp.frame_length,
                             status: sfd_pkg::status_type'(rsp.status)});
      end
      if (rsp_hold_left > 0) begin
         rsp.ready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp.ready <= no_idle || ($urandom_range(0, 99) >= 24);
      end
   end

   // offer one byte, with random gaps ahead of it
   task automatic send_byte(input logic [7:0] value);
      while (!no_idle && $urandom_range(0, 99) < 24) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.rx_byte <= value;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      frames.take_byte(value);
      items_sent++;
   endtask

   // stop sending until every due item has come, then let header bytes settle
   task automatic wait_for_drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (frames.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_check_enable(input logic value);
      wait_for_drain();
      csr.valid <= 1'b1;
      csr.check_enable <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      frames.set_check_enable(value);
   endtask

   // one frame; body may be shorter than len for a truncated frame
   task automatic send_frame(input int len, input int body, input bit with_check,
                             input bit good_check);
      logic [7:0] xor_sum;
      logic [7:0] value;
      int i;
      send_byte(8'($urandom_range(0, 255)));
      xor_sum = 8'($urandom_range(0, 255));
      send_byte(xor_sum);
      send_byte(len[7:0]);
      xor_sum = xor_sum ^ len[7:0];
      // oversized length: fourth byte closes the frame whatever it is
      if (len > sfd_pkg::MAX_PAYLOAD) begin
         send_byte(8'($urandom_range(0, 255)));
         return;
      end
      for (i = 0; i < body; i++) begin
         value = 8'($urandom_range(0, 255));
         xor_sum = xor_sum ^ value;
         send_byte(value);
      end
      if (with_check)
         send_byte(good_check ? xor_sum : xor_sum ^ 8'($urandom_range(1, 255)));
   endtask

   // mostly well-formed frames, some truncated frames and loose noise bytes
   task automatic send_random_traffic(input int until_count);
      int pick;
      int len;
      while (items_sent < until_count) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) len = $urandom_range(0, 12);
            else if (pick < 88) len = $urandom_range(13, 40);
            else if (pick < 90) len = $urandom_range(100, sfd_pkg::MAX_PAYLOAD);
            else len = $urandom_range(sfd_pkg::MAX_PAYLOAD + 1, 255);
            send_frame(len, len, 1'b1, $urandom_range(0, 3) != 0);
         end else if (pick < 87) begin
            len = $urandom_range(1, 20);
            send_frame(len, $urandom_range(0, len - 1), 1'b0, 1'b0);
         end else begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // main sequence
   initial begin
      frames = new();
      items_sent = 0;
      no_idle = 1'b0;
      rsp_hold_left = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.rx_byte = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.check_enable = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_check_enable(1'b1);
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (i == CHECK_OFF_AT) write_check_enable(1'b0);
         send_byte(DIRECTED_BYTES[i]);
      end

      // check byte ignored
      send_random_traffic(300);

      // check byte verified, receiver holds off while bytes keep coming
      write_check_enable(1'b1);
      rsp_hold_left = RSP_HOLD_CYCLES;
      send_random_traffic(650);
      wait_for_drain();

      // longest payload reaches the top byte index
      send_frame(sfd_pkg::MAX_PAYLOAD, sfd_pkg::MAX_PAYLOAD, 1'b1, 1'b1);

      // back-to-back stretch on both sides
      no_idle = 1'b1;
      send_random_traffic(900);
      no_idle = 1'b0;

      write_check_enable(1'b0);
      send_random_traffic(1000);
      write_check_enable(1'b1);
      send_random_traffic(1130);

      wait_for_drain();
      if (frames.errors == 0)
         $display("serial_frame_deframer: match");
      else
         $display("serial_frame_deframer: mismatch");
      $finish;
   end

endmodule
